/* src/aei_pkg.sv */
`default_nettype none

package aei_pkg;

  // Parser phase held by the front end.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_CSI
  } phase_t;

  // Action codes presented on the result channel.
  typedef enum logic [2:0] {
    ACT_CONSUMED = 3'd0,
    ACT_PASS     = 3'd1,
    ACT_CLS      = 3'd2,
    ACT_EOL      = 3'd3,
    ACT_MOVE     = 3'd4,
    ACT_ATTR     = 3'd5,
    ACT_BAD      = 3'd6
  } action_t;

  // Classification of a byte made by the front end.
  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_PASS,
    KIND_FINAL
  } kind_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_ATTR
  } back_state_t;

  // Character codes.
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_POS_H    = 8'h48;
  localparam logic [7:0] CH_CLS      = 8'h4A;
  localparam logic [7:0] CH_EOL      = 8'h4B;
  localparam logic [7:0] CH_POS_F    = 8'h66;
  localparam logic [7:0] CH_SGR      = 8'h6D;
  localparam logic [7:0] CH_SAVE     = 8'h73;
  localparam logic [7:0] CH_RESTORE  = 8'h75;

  // Attribute codes of the 'm' final.
  localparam logic [7:0] SGR_NORMAL    = 8'd0;
  localparam logic [7:0] SGR_BOLD      = 8'd1;
  localparam logic [7:0] SGR_UNDERLINE = 8'd4;
  localparam logic [7:0] SGR_BLINK     = 8'd5;
  localparam logic [7:0] SGR_REVERSE   = 8'd7;
  localparam logic [7:0] UNDERLINE_BIT = 8'h01;
  localparam logic [7:0] BLINK_BIT     = 8'h80;

  // Configuration register indexes.
  localparam logic [2:0] REG_NORMAL_ATTR   = 3'd0;
  localparam logic [2:0] REG_REVERSE_ATTR  = 3'd1;
  localparam logic [2:0] REG_BOLD_ATTR     = 3'd2;
  localparam logic [2:0] REG_LAST_ROW      = 3'd3;
  localparam logic [2:0] REG_COLUMN_COUNT  = 3'd4;
  localparam logic [2:0] REG_SCROLL_BOTTOM = 3'd5;

  // Configuration reset values.
  localparam logic [7:0] NORMAL_ATTR_RST   = 8'd7;
  localparam logic [7:0] REVERSE_ATTR_RST  = 8'd112;
  localparam logic [7:0] BOLD_ATTR_RST     = 8'd15;
  localparam logic [7:0] LAST_ROW_RST      = 8'd24;
  localparam logic [7:0] COLUMN_COUNT_RST  = 8'd80;
  localparam logic [7:0] SCROLL_BOTTOM_RST = 8'd23;

  typedef struct packed {
    logic [7:0] normal_attr;
    logic [7:0] reverse_attr;
    logic [7:0] bold_attr;
    logic [7:0] last_row;
    logic [7:0] column_count;
    logic [7:0] scroll_bottom;
  } cfg_t;

  // Command passed from the front end to the back end.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [7:0] row;
    logic [7:0] col;
    logic       lead_semi;
  } cmd_t;

endpackage

`default_nettype wire

/* src/aei_in_if.sv */
`default_nettype none

interface aei_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic [7:0] cursor_row;
  logic [7:0] cursor_col;

  modport source (output valid, output in_byte, output cursor_row, output cursor_col,
                  input ready);
  modport sink (input valid, input in_byte, input cursor_row, input cursor_col,
                output ready);
endinterface

`default_nettype wire

/* src/aei_out_if.sv */
`default_nettype none

interface aei_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] target_row;
  logic [7:0] target_col;
  logic [7:0] text_attr;
  logic [7:0] out_byte;
  logic       sequence_open;

  modport source (output valid, output action, output target_row, output target_col,
                  output text_attr, output out_byte, output sequence_open,
                  input ready);
  modport sink (input valid, input action, input target_row, input target_col,
                input text_attr, input out_byte, input sequence_open,
                output ready);
endinterface

`default_nettype wire

/* src/aei_front.sv */
`default_nettype none

module aei_front #(
  parameter int MAX_PARAMS = 5,
  localparam int CNT_W = $clog2(MAX_PARAMS + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  aei_in_if.sink                             in_ch,
  input  wire logic                          q_ready,
  output logic                               push,
  output aei_pkg::cmd_t                      cmd,
  output logic [MAX_PARAMS-1:0][7:0]         params,
  output logic [CNT_W-1:0]                   param_count
);

  aei_pkg::phase_t                  phase, phase_next;
  logic [MAX_PARAMS-1:0][7:0]       pv, pv_next;
  logic [CNT_W-1:0]                 cnt, cnt_next;
  logic                             in_digits, in_digits_next;
  logic                             lead_semi, lead_semi_next;
  logic                             any_char, any_char_next;
  aei_pkg::kind_t                   kind;
  logic                             accept;
  logic                             is_digit;
  logic                             is_letter;
  logic [7:0]                       b;
  logic [3:0]                       digit;

  assign b         = in_ch.in_byte;
  assign accept    = in_ch.valid && q_ready;
  assign is_digit  = (b >= aei_pkg::CH_ZERO) && (b <= aei_pkg::CH_NINE);
  assign is_letter = ((b >= aei_pkg::CH_UPPER_A) && (b <= aei_pkg::CH_UPPER_Z)) ||
                     ((b >= aei_pkg::CH_LOWER_A) && (b <= aei_pkg::CH_LOWER_Z));
  assign digit     = 4'(b - aei_pkg::CH_ZERO);

  // Phase tracking and parameter accumulation.
  always_comb begin
    phase_next     = phase;
    pv_next        = pv;
    cnt_next       = cnt;
    in_digits_next = in_digits;
    lead_semi_next = lead_semi;
    any_char_next  = any_char;
    kind           = aei_pkg::KIND_OPEN;
    if (accept) begin
      if (b == aei_pkg::CH_ESC) begin
        pv_next        = '0;
        cnt_next       = '0;
        in_digits_next = 1'b0;
        lead_semi_next = 1'b0;
        any_char_next  = 1'b0;
        phase_next     = aei_pkg::PH_ESC;
      end else begin
        unique case (phase)
          aei_pkg::PH_ESC: begin
            if (b == aei_pkg::CH_LBRACKET) begin
              phase_next = aei_pkg::PH_CSI;
            end else begin
              phase_next = aei_pkg::PH_IDLE;
              kind       = aei_pkg::KIND_PASS;
            end
          end
          aei_pkg::PH_CSI: begin
            if (is_letter) begin
              kind           = aei_pkg::KIND_FINAL;
              pv_next        = '0;
              cnt_next       = '0;
              in_digits_next = 1'b0;
              lead_semi_next = 1'b0;
              any_char_next  = 1'b0;
              phase_next     = aei_pkg::PH_IDLE;
            end else begin
              if (!any_char && (b == aei_pkg::CH_SEMI)) begin
                lead_semi_next = 1'b1;
              end
              any_char_next = 1'b1;
              if (is_digit) begin
                if (in_digits && (cnt != '0)) begin
                  // Extend the open parameter: value times ten plus digit.
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                    if (CNT_W'(i + 1) == cnt) begin
                      pv_next[i] = 8'({pv[i], 3'b000} + {pv[i], 1'b0} + {4'b0000, digit});
                    end
                  end
                end else if (cnt < CNT_W'(MAX_PARAMS)) begin
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                    if (CNT_W'(i) == cnt) begin
                      pv_next[i] = {4'b0000, digit};
                    end
                  end
                  cnt_next       = cnt + CNT_W'(1);
                  in_digits_next = 1'b1;
                end
              end else begin
                in_digits_next = 1'b0;
              end
            end
          end
          default: begin
            phase_next = aei_pkg::PH_IDLE;
            kind       = aei_pkg::KIND_PASS;
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= aei_pkg::PH_IDLE;
      pv        <= '0;
      cnt       <= '0;
      in_digits <= 1'b0;
      lead_semi <= 1'b0;
      any_char  <= 1'b0;
    end else begin
      phase     <= phase_next;
      pv        <= pv_next;
      cnt       <= cnt_next;
      in_digits <= in_digits_next;
      lead_semi <= lead_semi_next;
      any_char  <= any_char_next;
    end
  end

  // Every accepted byte becomes one command; a final carries the parameters seen so far.
  assign in_ch.ready   = q_ready;
  assign push          = accept;
  assign cmd.kind      = kind;
  assign cmd.ch        = b;
  assign cmd.row       = in_ch.cursor_row;
  assign cmd.col       = in_ch.cursor_col;
  assign cmd.lead_semi = lead_semi;
  assign params        = pv;
  assign param_count   = cnt;

  a_esc_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && (b == aei_pkg::CH_ESC)) |=> (phase == aei_pkg::PH_ESC) && (cnt == '0))
    else $error("ESC did not restart the sequence");

endmodule

`default_nettype wire

/* src/aei_queue.sv */
`default_nettype none

module aei_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  output logic                  valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata
);

  localparam int DEPTH = 2;

  logic [DEPTH-1:0][WIDTH-1:0] entry;
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;

  assign full  = (count == 2'(DEPTH));
  assign valid = (count != 2'd0);
  assign rdata = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("Queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Queue pushed while full");

endmodule

`default_nettype wire

/* src/aei_back.sv */
`default_nettype none

module aei_back #(
  parameter int MAX_PARAMS = 5,
  localparam int CNT_W = $clog2(MAX_PARAMS + 1),
  localparam int IDX_W = $clog2(MAX_PARAMS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire aei_pkg::cfg_t                 cfg,
  input  wire logic                          q_valid,
  input  wire aei_pkg::cmd_t                 cmd,
  input  wire logic [MAX_PARAMS-1:0][7:0]    params,
  input  wire logic [CNT_W-1:0]              param_count,
  output logic                               pop,
  aei_out_if.source                          out_ch
);

  aei_pkg::back_state_t       state, state_next;
  logic [7:0]                 cur_attr;
  logic [7:0]                 saved_row;
  logic [7:0]                 saved_col;
  logic [MAX_PARAMS-1:0][7:0] hp;
  logic [CNT_W-1:0]           hc;
  logic [IDX_W-1:0]           idx;
  logic                       idx_last;
  logic [7:0]                 attr_stepped;
  logic                       can_load;
  logic                       load;
  logic                       start;
  logic                       step;
  logic                       is_attr_multi;

  logic                       out_valid;
  aei_pkg::action_t           out_action;
  logic [7:0]                 out_row;
  logic [7:0]                 out_col;
  logic [7:0]                 out_attr;
  logic [7:0]                 out_ch_byte;
  logic                       out_open;

  aei_pkg::action_t           d_act;
  logic [7:0]                 d_row;
  logic [7:0]                 d_col;
  logic [7:0]                 d_byte;
  logic                       d_open;
  logic                       save_en;

  logic [7:0]                 n;
  logic [8:0]                 row_sum;
  logic [8:0]                 col_sum;
  logic [7:0]                 p0;
  logic [7:0]                 p1;
  logic                       pos_ok;

  // One attribute code applied to the running attribute.
  function automatic logic [7:0] attr_step(input logic [7:0] code, input logic [7:0] cur,
                                           input aei_pkg::cfg_t c);
    logic [7:0] r;
    r = cur;
    unique case (code)
      aei_pkg::SGR_NORMAL:    r = c.normal_attr;
      aei_pkg::SGR_BOLD:      r = c.bold_attr;
      aei_pkg::SGR_UNDERLINE: r = cur | aei_pkg::UNDERLINE_BIT;
      aei_pkg::SGR_BLINK:     r = cur | aei_pkg::BLINK_BIT;
      aei_pkg::SGR_REVERSE:   r = c.reverse_attr;
      default:                r = cur;
    endcase
    return r;
  endfunction

  // Operands of the relative moves; n is shared by all four.
  assign n       = (param_count != '0) ? params[0] : 8'd1;
  assign row_sum = {1'b0, cmd.row} + {1'b0, n};
  assign col_sum = {1'b0, cmd.col} + {1'b0, n};

  // Absolute position: a lone parameter after a leading ';' is the column.
  always_comb begin
    if (param_count == CNT_W'(1)) begin
      p0 = cmd.lead_semi ? 8'd1 : params[0];
      p1 = cmd.lead_semi ? params[0] : 8'd1;
    end else begin
      p0 = params[0];
      p1 = params[1];
    end
    if (p0 == 8'd0) begin
      p0 = 8'd1;
    end
    if (p1 == 8'd0) begin
      p1 = 8'd1;
    end
  end
  assign pos_ok = (p0 <= cfg.last_row) && (p1 < cfg.column_count);

  // Decode of a command into its result.
  always_comb begin
    d_act   = aei_pkg::ACT_CONSUMED;
    d_row   = 8'd0;
    d_col   = 8'd0;
    d_byte  = 8'd0;
    d_open  = 1'b0;
    save_en = 1'b0;
    unique case (cmd.kind)
      aei_pkg::KIND_OPEN: begin
        d_open = 1'b1;
      end
      aei_pkg::KIND_PASS: begin
        d_act  = aei_pkg::ACT_PASS;
        d_byte = cmd.ch;
      end
      aei_pkg::KIND_FINAL: begin
        unique case (cmd.ch)
          aei_pkg::CH_CLS: d_act = aei_pkg::ACT_CLS;
          aei_pkg::CH_EOL: begin
            d_act = aei_pkg::ACT_EOL;
            d_row = cmd.row;
            d_col = cmd.col;
          end
          aei_pkg::CH_SGR:  d_act = aei_pkg::ACT_ATTR;
          aei_pkg::CH_SAVE: save_en = 1'b1;
          aei_pkg::CH_RESTORE: begin
            d_act = aei_pkg::ACT_MOVE;
            d_row = saved_row;
            d_col = saved_col;
          end
          aei_pkg::CH_UP: begin
            d_act = aei_pkg::ACT_MOVE;
            d_row = (cmd.row >= n) ? cmd.row - n : cmd.row;
            d_col = cmd.col;
          end
          aei_pkg::CH_DOWN: begin
            d_act = aei_pkg::ACT_MOVE;
            d_row = (row_sum < {1'b0, cfg.scroll_bottom}) ? row_sum[7:0] : cmd.row;
            d_col = cmd.col;
          end
          aei_pkg::CH_LEFT: begin
            d_act = aei_pkg::ACT_MOVE;
            d_row = cmd.row;
            d_col = (cmd.col >= n) ? cmd.col - n : cmd.col;
          end
          aei_pkg::CH_RIGHT: begin
            d_act = aei_pkg::ACT_MOVE;
            d_row = cmd.row;
            d_col = (col_sum < {1'b0, cfg.column_count}) ? col_sum[7:0] : cmd.col;
          end
          aei_pkg::CH_POS_H, aei_pkg::CH_POS_F: begin
            if (param_count == '0) begin
              d_act = aei_pkg::ACT_MOVE;
            end else if (param_count > CNT_W'(2)) begin
              d_act = aei_pkg::ACT_BAD;
            end else if (pos_ok) begin
              d_act = aei_pkg::ACT_MOVE;
              d_row = p0 - 8'd1;
              d_col = p1 - 8'd1;
            end else begin
              d_act = aei_pkg::ACT_BAD;
            end
          end
          default: d_act = aei_pkg::ACT_BAD;
        endcase
      end
      default: begin
        d_act = aei_pkg::ACT_BAD;
      end
    endcase
  end

  assign is_attr_multi = (cmd.kind == aei_pkg::KIND_FINAL) && (cmd.ch == aei_pkg::CH_SGR) &&
                         (param_count != '0);
  assign can_load      = !out_valid || out_ch.ready;
  assign idx_last      = ((CNT_W'(idx) + CNT_W'(1)) == hc);
  assign attr_stepped  = attr_step(hp[idx], cur_attr, cfg);

  // Sequencer: loads, or one attribute code per cycle; the last can stall.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    start      = 1'b0;
    step       = 1'b0;
    unique case (state)
      aei_pkg::BK_IDLE: begin
        if (q_valid && can_load) begin
          pop = 1'b1;
          if (is_attr_multi) begin
            start      = 1'b1;
            state_next = aei_pkg::BK_ATTR;
          end else begin
            load = 1'b1;
          end
        end
      end
      aei_pkg::BK_ATTR: begin
        if (!idx_last) begin
          step = 1'b1;
        end else if (can_load) begin
          step       = 1'b1;
          load       = 1'b1;
          state_next = aei_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = aei_pkg::BK_IDLE;
      end
    endcase
  end

  // Control and kept state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= aei_pkg::BK_IDLE;
      out_valid <= 1'b0;
      cur_attr  <= aei_pkg::NORMAL_ATTR_RST;
      saved_row <= 8'd0;
      saved_col <= 8'd0;
      idx       <= '0;
      hc        <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        hc  <= param_count;
        idx <= '0;
      end
      if (step) begin
        cur_attr <= attr_stepped;
        idx      <= idx + IDX_W'(1);
      end
      if (pop && save_en) begin
        saved_row <= cmd.row;
        saved_col <= cmd.col;
      end
    end
  end

  // Held parameters and result register.
  always_ff @(posedge clk) begin
    if (start) begin
      hp <= params;
    end
    if (load) begin
      if (state == aei_pkg::BK_ATTR) begin
        out_action  <= aei_pkg::ACT_ATTR;
        out_row     <= 8'd0;
        out_col     <= 8'd0;
        out_attr    <= attr_stepped;
        out_ch_byte <= 8'd0;
        out_open    <= 1'b0;
      end else begin
        out_action  <= d_act;
        out_row     <= d_row;
        out_col     <= d_col;
        out_attr    <= cur_attr;
        out_ch_byte <= d_byte;
        out_open    <= d_open;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.action        = out_action;
  assign out_ch.target_row    = out_row;
  assign out_ch.target_col    = out_col;
  assign out_ch.text_attr     = out_attr;
  assign out_ch.out_byte      = out_ch_byte;
  assign out_ch.sequence_open = out_open;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == aei_pkg::BK_ATTR) |-> (CNT_W'(idx) < hc))
    else $error("Attribute index ran past the parameter count");

endmodule

`default_nettype wire

/* src/ansi_escape_interpreter_top.sv */
`default_nettype none

// A byte's result is registered in the command queue, then in the result register, before
// its transaction; an 'm' final with parameters also steps through the attribute sequencer.
// Throughput: one byte per cycle; such an 'm' holds the back end while it applies its
// attribute codes in turn, and the parser stalls once the two-entry command queue is full.
// Reset (synchronous, rst high) restores the register defaults, idle phase, cleared
// parameters and saved cursor, and the normal attribute; no clearing pass.
module ansi_escape_interpreter_top #(
  parameter int MAX_PARAMS = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  aei_in_if.sink          in_ch,
  aei_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int QW    = $bits(aei_pkg::cmd_t) + MAX_PARAMS * 8 + CNT_W;

  aei_pkg::cfg_t              cfg;
  aei_pkg::cmd_t              f_cmd;
  aei_pkg::cmd_t              b_cmd;
  logic [MAX_PARAMS-1:0][7:0] f_params;
  logic [MAX_PARAMS-1:0][7:0] b_params;
  logic [CNT_W-1:0]           f_count;
  logic [CNT_W-1:0]           b_count;
  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_valid;
  logic [QW-1:0]              q_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_attr   <= aei_pkg::NORMAL_ATTR_RST;
      cfg.reverse_attr  <= aei_pkg::REVERSE_ATTR_RST;
      cfg.bold_attr     <= aei_pkg::BOLD_ATTR_RST;
      cfg.last_row      <= aei_pkg::LAST_ROW_RST;
      cfg.column_count  <= aei_pkg::COLUMN_COUNT_RST;
      cfg.scroll_bottom <= aei_pkg::SCROLL_BOTTOM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aei_pkg::REG_NORMAL_ATTR:   cfg.normal_attr   <= cfg_data;
        aei_pkg::REG_REVERSE_ATTR:  cfg.reverse_attr  <= cfg_data;
        aei_pkg::REG_BOLD_ATTR:     cfg.bold_attr     <= cfg_data;
        aei_pkg::REG_LAST_ROW:      cfg.last_row      <= cfg_data;
        aei_pkg::REG_COLUMN_COUNT:  cfg.column_count  <= cfg_data;
        aei_pkg::REG_SCROLL_BOTTOM: cfg.scroll_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte parser.
  aei_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .q_ready     (!q_full),
    .push        (push),
    .cmd         (f_cmd),
    .params      (f_params),
    .param_count (f_count)
  );

  // Command queue.
  aei_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_cmd, f_params, f_count}),
    .full  (q_full),
    .valid (q_valid),
    .pop   (pop),
    .rdata (q_rdata)
  );

  assign {b_cmd, b_params, b_count} = q_rdata;

  // Command execution and result register.
  aei_back #(.MAX_PARAMS(MAX_PARAMS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .cmd         (b_cmd),
    .params      (b_params),
    .param_count (b_count),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_ansi_escape_interpreter_top.sv */
`timescale 1ns / 100ps

module tb_ansi_escape_interpreter_top;

  localparam int PARAM_SLOTS = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_BYTES = 125;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
  } byte_item_t;

  typedef struct packed {
    aei_pkg::action_t action;
    logic [7:0]       target_row;
    logic [7:0]       target_col;
    logic [7:0]       text_attr;
    logic [7:0]       out_byte;
    logic             sequence_open;
  } display_action_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  aei_in_if  in_ch ();
  aei_out_if out_ch ();

  ansi_escape_interpreter_top #(
    .MAX_PARAMS(PARAM_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the interpreter's registers and sequence state.
  aei_pkg::cfg_t   shadow_cfg;
  aei_pkg::phase_t seq_phase;
  logic [7:0]      par_val [PARAM_SLOTS];
  int              par_cnt;
  bit              in_digits;
  bit              lead_semi;
  bit              any_char;
  logic [7:0]      saved_row;
  logic [7:0]      saved_col;
  logic [7:0]      attr_now;

  byte_item_t      byte_queue [$];
  display_action_t expected_actions [$];

  int bytes_queued;
  int bytes_accepted;
  int results_checked;
  int mismatches;
  int config_sets;
  int cycle_count;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 31);
  endfunction

  function automatic void clear_sequence();
    for (int i = 0; i < PARAM_SLOTS; i++) par_val[i] = '0;
    par_cnt   = 0;
    in_digits = 1'b0;
    lead_semi = 1'b0;
    any_char  = 1'b0;
  endfunction

  // Works out the display action caused by one received byte and advances the shadow state.
  function automatic display_action_t interpret_byte(input logic [7:0] b,
                                                     input logic [7:0] row,
                                                     input logic [7:0] col);
    display_action_t r;
    int n, ri, ci, p0, p1, d;
    r.action        = aei_pkg::ACT_CONSUMED;
    r.target_row    = '0;
    r.target_col    = '0;
    r.out_byte      = '0;
    r.sequence_open = 1'b1;
    ri = int'(row);
    ci = int'(col);
    if (b == aei_pkg::CH_ESC) begin
      clear_sequence();
      seq_phase = aei_pkg::PH_ESC;
    end else if (seq_phase == aei_pkg::PH_ESC) begin
      if (b == aei_pkg::CH_LBRACKET) begin
        seq_phase = aei_pkg::PH_CSI;
      end else begin
        seq_phase       = aei_pkg::PH_IDLE;
        r.action        = aei_pkg::ACT_PASS;
        r.out_byte      = b;
        r.sequence_open = 1'b0;
      end
    end else if (seq_phase == aei_pkg::PH_CSI) begin
      if ((b >= aei_pkg::CH_UPPER_A && b <= aei_pkg::CH_UPPER_Z) ||
          (b >= aei_pkg::CH_LOWER_A && b <= aei_pkg::CH_LOWER_Z)) begin
        n = (par_cnt != 0) ? int'(par_val[0]) : 1;
        case (b)
          aei_pkg::CH_CLS: r.action = aei_pkg::ACT_CLS;
          aei_pkg::CH_EOL: begin
            r.action     = aei_pkg::ACT_EOL;
            r.target_row = row;
            r.target_col = col;
          end
          aei_pkg::CH_SGR: begin
            r.action = aei_pkg::ACT_ATTR;
            for (int i = 0; i < par_cnt; i++) begin
              case (par_val[i])
                aei_pkg::SGR_NORMAL:    attr_now = shadow_cfg.normal_attr;
                aei_pkg::SGR_BOLD:      attr_now = shadow_cfg.bold_attr;
                aei_pkg::SGR_UNDERLINE: attr_now = attr_now | aei_pkg::UNDERLINE_BIT;
                aei_pkg::SGR_BLINK:     attr_now = attr_now | aei_pkg::BLINK_BIT;
                aei_pkg::SGR_REVERSE:   attr_now = shadow_cfg.reverse_attr;
                default: ;
              endcase
            end
          end
          aei_pkg::CH_SAVE: begin
            saved_row = row;
            saved_col = col;
          end
          aei_pkg::CH_RESTORE: begin
            r.action     = aei_pkg::ACT_MOVE;
            r.target_row = saved_row;
            r.target_col = saved_col;
          end
          aei_pkg::CH_UP: begin
            r.action     = aei_pkg::ACT_MOVE;
            r.target_row = 8'((ri >= n) ? ri - n : ri);
            r.target_col = col;
          end
          aei_pkg::CH_DOWN: begin
            r.action     = aei_pkg::ACT_MOVE;
            r.target_row = 8'((ri + n < int'(shadow_cfg.scroll_bottom)) ? ri + n : ri);
            r.target_col = col;
          end
          aei_pkg::CH_LEFT: begin
            r.action     = aei_pkg::ACT_MOVE;
            r.target_row = row;
            r.target_col = 8'((ci >= n) ? ci - n : ci);
          end
          aei_pkg::CH_RIGHT: begin
            r.action     = aei_pkg::ACT_MOVE;
            r.target_row = row;
            r.target_col = 8'((ci + n < int'(shadow_cfg.column_count)) ? ci + n : ci);
          end
          aei_pkg::CH_POS_H, aei_pkg::CH_POS_F: begin
            if (par_cnt == 0) begin
              r.action = aei_pkg::ACT_MOVE;
            end else if (par_cnt > 2) begin
              r.action = aei_pkg::ACT_BAD;
            end else begin
              // A lone parameter after a leading semicolon is the column.
              if (par_cnt == 1) begin
                if (lead_semi) begin
                  p0 = 1;
                  p1 = int'(par_val[0]);
                end else begin
                  p0 = int'(par_val[0]);
                  p1 = 1;
                end
              end else begin
                p0 = int'(par_val[0]);
                p1 = int'(par_val[1]);
              end
              if (p0 == 0) p0 = 1;
              if (p1 == 0) p1 = 1;
              if (p0 <= int'(shadow_cfg.last_row) && p1 < int'(shadow_cfg.column_count)) begin
                r.action     = aei_pkg::ACT_MOVE;
                r.target_row = 8'(p0 - 1);
                r.target_col = 8'(p1 - 1);
              end else begin
                r.action = aei_pkg::ACT_BAD;
              end
            end
          end
          default: r.action = aei_pkg::ACT_BAD;
        endcase
        clear_sequence();
        seq_phase       = aei_pkg::PH_IDLE;
        r.sequence_open = 1'b0;
      end else begin
        // Parameter byte: digits build a value modulo 256, anything else ends the run.
        if (!any_char && b == aei_pkg::CH_SEMI) lead_semi = 1'b1;
        any_char = 1'b1;
        if (b >= aei_pkg::CH_ZERO && b <= aei_pkg::CH_NINE) begin
          d = int'(b) - int'(aei_pkg::CH_ZERO);
          if (in_digits && par_cnt > 0) begin
            par_val[par_cnt - 1] = 8'(int'(par_val[par_cnt - 1]) * 10 + d);
          end else if (par_cnt < PARAM_SLOTS) begin
            par_val[par_cnt] = 8'(d);
            par_cnt++;
            in_digits = 1'b1;
          end
        end else begin
          in_digits = 1'b0;
        end
      end
    end else begin
      seq_phase       = aei_pkg::PH_IDLE;
      r.action        = aei_pkg::ACT_PASS;
      r.out_byte      = b;
      r.sequence_open = 1'b0;
    end
    r.text_attr = attr_now;
    return r;
  endfunction

  // Byte driver: presents queued bytes and predicts each accepted transaction.
  always @(posedge clk) begin
    byte_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_actions.push_back(interpret_byte(in_ch.in_byte, in_ch.cursor_row,
                                                  in_ch.cursor_col));
        bytes_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() != 0 && !take_break()) begin
          nxt = byte_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.in_byte    <= nxt.in_byte;
          in_ch.cursor_row <= nxt.cursor_row;
          in_ch.cursor_col <= nxt.cursor_col;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted transaction with the oldest prediction.
  always @(posedge clk) begin
    display_action_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_actions.size() == 0) begin
          $error("unexpected result: action %0d", out_ch.action);
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          results_checked++;
          if (out_ch.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, out_ch.action);
            mismatches++;
          end
          if (out_ch.target_row !== want.target_row) begin
            $error("target_row: expected %0d, actual %0d", want.target_row, out_ch.target_row);
            mismatches++;
          end
          if (out_ch.target_col !== want.target_col) begin
            $error("target_col: expected %0d, actual %0d", want.target_col, out_ch.target_col);
            mismatches++;
          end
          if (out_ch.text_attr !== want.text_attr) begin
            $error("text_attr: expected %0d, actual %0d", want.text_attr, out_ch.text_attr);
            mismatches++;
          end
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.sequence_open !== want.sequence_open) begin
            $error("sequence_open: expected %0d, actual %0d", want.sequence_open,
                   out_ch.sequence_open);
            mismatches++;
          end
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    byte_item_t it;
    it.in_byte = b;
    if ($urandom_range(0, 1)) begin
      it.cursor_row = 8'($urandom);
      it.cursor_col = 8'($urandom);
    end else begin
      // Keep the cursor near the screen bounds so that move limits are exercised.
      it.cursor_row = 8'($urandom_range(0, int'(shadow_cfg.last_row) + 1));
      it.cursor_col = 8'($urandom_range(0, int'(shadow_cfg.column_count)));
    end
    byte_queue.push_back(it);
    bytes_queued++;
  endtask

  // One well-formed control sequence with random final and parameters.
  task automatic queue_control_sequence();
    logic [7:0] fin;
    int         n_par, v;
    string      digits;
    case ($urandom_range(0, 11))
      0:  fin = aei_pkg::CH_UP;
      1:  fin = aei_pkg::CH_DOWN;
      2:  fin = aei_pkg::CH_RIGHT;
      3:  fin = aei_pkg::CH_LEFT;
      4:  fin = aei_pkg::CH_POS_H;
      5:  fin = aei_pkg::CH_POS_F;
      6:  fin = aei_pkg::CH_CLS;
      7:  fin = aei_pkg::CH_EOL;
      8:  fin = aei_pkg::CH_SGR;
      9:  fin = aei_pkg::CH_SAVE;
      10: fin = aei_pkg::CH_RESTORE;
      default: fin = $urandom_range(0, 1)
                     ? 8'($urandom_range(aei_pkg::CH_UPPER_A, aei_pkg::CH_UPPER_Z))
                     : 8'($urandom_range(aei_pkg::CH_LOWER_A, aei_pkg::CH_LOWER_Z));
    endcase
    queue_byte(aei_pkg::CH_ESC);
    queue_byte(aei_pkg::CH_LBRACKET);
    if ($urandom_range(0, 5) == 0) queue_byte(aei_pkg::CH_SEMI);
    n_par = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 7);
    for (int i = 0; i < n_par; i++) begin
      if (i > 0) begin
        case ($urandom_range(0, 9))
          0:       queue_byte(8'($urandom_range(128, 255)));
          1:       queue_byte(8'($urandom_range(8'h20, 8'h2F)));
          default: queue_byte(aei_pkg::CH_SEMI);
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        v = $urandom_range(0, 999);
      end else if (fin == aei_pkg::CH_SGR) begin
        case ($urandom_range(0, 6))
          0:       v = int'(aei_pkg::SGR_NORMAL);
          1:       v = int'(aei_pkg::SGR_BOLD);
          2:       v = int'(aei_pkg::SGR_UNDERLINE);
          3:       v = int'(aei_pkg::SGR_BLINK);
          4:       v = int'(aei_pkg::SGR_REVERSE);
          default: v = $urandom_range(0, 12);
        endcase
      end else if (fin == aei_pkg::CH_POS_H || fin == aei_pkg::CH_POS_F) begin
        v = (i == 0) ? $urandom_range(0, int'(shadow_cfg.last_row) + 2)
                     : $urandom_range(0, int'(shadow_cfg.column_count) + 1);
      end else begin
        v = $urandom_range(0, 9);
      end
      digits = $sformatf("%0d", v);
      foreach (digits[k]) queue_byte(digits[k]);
    end
    queue_byte(fin);
  endtask

  // Mostly complete sequences, with plain text, broken escapes and noise mixed in.
  task automatic queue_random_traffic(input int count);
    int         start;
    logic [7:0] b;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2: queue_byte(8'($urandom));
        3, 4: begin
          b = 8'($urandom);
          if (b == aei_pkg::CH_LBRACKET) b = aei_pkg::CH_SEMI;
          queue_byte(aei_pkg::CH_ESC);
          queue_byte(b);
        end
        5: begin
          // Sequence cut short by a fresh escape or by a stray byte.
          queue_byte(aei_pkg::CH_ESC);
          queue_byte(aei_pkg::CH_LBRACKET);
          queue_byte(8'($urandom_range(aei_pkg::CH_ZERO, aei_pkg::CH_NINE)));
          queue_byte($urandom_range(0, 1) ? aei_pkg::CH_ESC : 8'($urandom));
        end
        default: queue_control_sequence();
      endcase
    end
  endtask

  // Waits until every byte has been accepted and every result checked.
  task automatic settle();
    while (bytes_accepted != bytes_queued || expected_actions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  task automatic apply_settings(input aei_pkg::cfg_t c);
    settle();
    write_reg(aei_pkg::REG_NORMAL_ATTR, c.normal_attr);
    write_reg(aei_pkg::REG_REVERSE_ATTR, c.reverse_attr);
    write_reg(aei_pkg::REG_BOLD_ATTR, c.bold_attr);
    write_reg(aei_pkg::REG_LAST_ROW, c.last_row);
    write_reg(aei_pkg::REG_COLUMN_COUNT, c.column_count);
    write_reg(aei_pkg::REG_SCROLL_BOTTOM, c.scroll_bottom);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = c;
    config_sets++;
  endtask

  function automatic aei_pkg::cfg_t random_settings();
    aei_pkg::cfg_t c;
    c.normal_attr   = 8'($urandom);
    c.reverse_attr  = 8'($urandom);
    c.bold_attr     = 8'($urandom);
    c.last_row      = 8'($urandom_range(1, 255));
    c.column_count  = 8'($urandom_range(40, 255));
    c.scroll_bottom = 8'($urandom);
    return c;
  endfunction

  initial begin
    logic [7:0]    directed [$];
    aei_pkg::cfg_t c;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = aei_pkg::REG_NORMAL_ATTR;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.in_byte    = '0;
    in_ch.cursor_row = '0;
    in_ch.cursor_col = '0;
    out_ch.ready     = 1'b0;
    steady           = 1'b0;

    shadow_cfg = '{aei_pkg::NORMAL_ATTR_RST, aei_pkg::REVERSE_ATTR_RST,
                   aei_pkg::BOLD_ATTR_RST, aei_pkg::LAST_ROW_RST,
                   aei_pkg::COLUMN_COUNT_RST, aei_pkg::SCROLL_BOTTOM_RST};
    clear_sequence();
    seq_phase = aei_pkg::PH_IDLE;
    saved_row = '0;
    saved_col = '0;
    attr_now  = aei_pkg::NORMAL_ATTR_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes: pass-through extremes, an escape not followed by a bracket,
    // clear screen, a column-only position after a leading semicolon, attributes,
    // save and restore, an upward move of nine rows, and an unknown final.
    directed = {8'h00, 8'hFF,
                aei_pkg::CH_ESC, 8'h71,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, aei_pkg::CH_CLS,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, aei_pkg::CH_SEMI, 8'h35,
                aei_pkg::CH_POS_H,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, 8'h31, aei_pkg::CH_SEMI, 8'h34,
                aei_pkg::CH_SGR,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, aei_pkg::CH_SAVE,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, aei_pkg::CH_NINE, aei_pkg::CH_UP,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, aei_pkg::CH_RESTORE,
                aei_pkg::CH_ESC, aei_pkg::CH_LBRACKET, 8'h7A};
    foreach (directed[k]) queue_byte(directed[k]);

    // Lowest register values.
    c = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd40, 8'd0};
    apply_settings(c);
    queue_random_traffic(PHASE_BYTES);

    // Highest register values.
    c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    apply_settings(c);
    queue_random_traffic(PHASE_BYTES);

    // Random registers with both sides running flat out.
    apply_settings(random_settings());
    settle();
    steady = 1'b1;
    queue_random_traffic(PHASE_BYTES);
    settle();
    steady = 1'b0;

    apply_settings(random_settings());
    queue_random_traffic(PHASE_BYTES);

    settle();
    $display("Checked %0d display actions from %0d bytes across %0d register settings.",
             results_checked, bytes_accepted, config_sets + 1);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
